// File: src/aabb_overlap_query_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for aabb_overlap_query_top
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef AABB_OVERLAP_QUERY_TOP_ASSERT_SVH
`define AABB_OVERLAP_QUERY_TOP_ASSERT_SVH

// same-cycle implication
`define AABB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define AABB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/aabb_pkg.sv
// ----------------------------------------------------------------------------
// aabb_pkg
// Shared constants, types and per-axis arithmetic for the rectangle
// overlap query block.
// ----------------------------------------------------------------------------
package aabb_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int MAX_SCAN    = 16;
	localparam int ENTRY_W     = 62;
	localparam int COUNT_W     = 5;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// query radius + entry radius - |query center - entry center|
	function automatic logic signed [17:0] axis_sum(
		input logic signed [15:0] qp,
		input logic        [14:0] qr,
		input logic signed [15:0] ep,
		input logic        [14:0] er
	);
		logic signed [16:0] d;
		logic        [16:0] ad;
		d  = $signed({qp[15], qp}) - $signed({ep[15], ep});
		ad = d[16] ? 17'(-d) : 17'(d);
		return $signed({3'b000, qr}) + $signed({3'b000, er}) - $signed({1'b0, ad});
	endfunction

	// intersection center from a positive sum, saturated to 16 bits
	function automatic logic signed [15:0] axis_center(
		input logic signed [17:0] sum,
		input logic               gt,
		input logic signed [15:0] ep,
		input logic        [14:0] er
	);
		logic        [14:0] h;
		logic signed [17:0] c;
		h = sum[15:1];
		if (gt) begin
			c = $signed({{2{ep[15]}}, ep}) + $signed({3'b000, er}) - $signed({3'b000, h});
		end else begin
			c = $signed({{2{ep[15]}}, ep}) - $signed({3'b000, er}) + $signed({3'b000, h});
		end
		if (c > 18'sd32767) begin
			return 16'sh7FFF;
		end else if (c < -18'sd32768) begin
			return 16'sh8000;
		end else begin
			return c[15:0];
		end
	endfunction

endpackage

// File: src/aabb_ram.sv
// ----------------------------------------------------------------------------
// aabb_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module aabb_ram #(
	parameter int WIDTH = 62,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: src/aabb_overlap_query_top.sv
// ----------------------------------------------------------------------------
// aabb_overlap_query_top
// Rectangle table with overlap query. Writes store one entry; a query scans
// the entries in use and reports every overlapping entry.
// ----------------------------------------------------------------------------
// A write is taken when busy is low, and busy stays low. A query holds busy high
// over a scan of count entries, where count is the smaller of entries_in_use,
// ENTRIES and 16, and over what follows the last read: the RAM output stage,
// the compute stage, a drain check and a final state. The table RAM gives one
// entry per cycle. Results come out on strobe for one cycle each and cannot be
// held off; the last one carries last and appears in the cycle in which busy
// falls. A query with no overlapping entry gives one result with hit low.
// A hit is held one step so that the final hit can carry last.
// ----------------------------------------------------------------------------
`include "aabb_overlap_query_top_assert.svh"

module aabb_overlap_query_top #(
	parameter int ENTRIES = aabb_pkg::ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic                               cmd,
	input  logic        [3:0]                  entry_index,
	input  logic signed [15:0]                 pos_x,
	input  logic signed [15:0]                 pos_y,
	input  logic        [14:0]                 radius_x,
	input  logic        [14:0]                 radius_y,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic        [aabb_pkg::COUNT_W-1:0] cfg_data,
	output logic                               strobe,
	output logic                               hit,
	output logic        [3:0]                  match_index,
	output logic signed [15:0]                 overlap_center_x,
	output logic signed [15:0]                 overlap_center_y,
	output logic        [14:0]                 overlap_half_x,
	output logic        [14:0]                 overlap_half_y,
	output logic                               last
);

	localparam int AW       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int SCAN_LIM = (ENTRIES < aabb_pkg::MAX_SCAN) ? ENTRIES : aabb_pkg::MAX_SCAN;
	localparam int CW       = aabb_pkg::COUNT_W;

	aabb_pkg::state_t state_q, state_d;

	logic [CW-1:0] entries_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] scan_q;
	logic [CW-1:0] count_sel;

	logic signed [15:0] qpx_q, qpy_q;
	logic        [14:0] qrx_q, qry_q;

	logic                       accept, wr_en, query_go, rd_en, finish;
	logic [aabb_pkg::ENTRY_W-1:0] rd_data;

	logic               v_s1;
	logic [3:0]         idx_s1;
	logic signed [15:0] epx_s1, epy_s1;
	logic        [14:0] erx_s1, ery_s1;

	logic               v_s2;
	logic [3:0]         idx_s2;
	logic signed [17:0] sx_s2, sy_s2;
	logic               gtx_s2, gty_s2;
	logic signed [15:0] epx_s2, epy_s2;
	logic        [14:0] erx_s2, ery_s2;

	logic               hit_s2;
	logic signed [15:0] cx_s2, cy_s2;

	logic               pv_q;
	logic [3:0]         pidx_q;
	logic signed [15:0] pcx_q, pcy_q;
	logic        [14:0] phx_q, phy_q;

	logic               strobe_q, hit_q, last_q;
	logic [3:0]         idx_q;
	logic signed [15:0] cx_q, cy_q;
	logic        [14:0] hx_q, hy_q;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign wr_en     = accept && (cmd == aabb_pkg::CMD_WRITE)
		&& (7'(entry_index) < 7'(ENTRIES));
	assign query_go  = accept && (cmd == aabb_pkg::CMD_QUERY);

	always_comb begin
		if (7'(entries_q) < 7'(SCAN_LIM)) begin
			count_sel = entries_q;
		end else begin
			count_sel = CW'(SCAN_LIM);
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			aabb_pkg::ST_IDLE: begin
				if (query_go) state_d = aabb_pkg::ST_SCAN;
			end
			aabb_pkg::ST_SCAN: begin
				if (scan_q == count_q) state_d = aabb_pkg::ST_DRAIN;
			end
			aabb_pkg::ST_DRAIN: begin
				if (!v_s1 && !v_s2) state_d = aabb_pkg::ST_FINISH;
			end
			aabb_pkg::ST_FINISH: begin
				state_d = aabb_pkg::ST_IDLE;
			end
			default: state_d = aabb_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		busy   = 1'b1;
		rd_en  = 1'b0;
		finish = 1'b0;
		unique case (state_q)
			aabb_pkg::ST_IDLE:   busy = 1'b0;
			aabb_pkg::ST_SCAN:   rd_en = (scan_q != count_q);
			aabb_pkg::ST_DRAIN:  ;
			aabb_pkg::ST_FINISH: finish = 1'b1;
			default:             busy = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= aabb_pkg::ST_IDLE;
			entries_q <= '0;
			scan_q    <= '0;
			count_q   <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			pv_q      <= 1'b0;
			strobe_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			v_s1     <= rd_en;
			v_s2     <= v_s1;
			strobe_q <= finish || (v_s2 && hit_s2 && pv_q);
			if (cfg_valid && cfg_ready) begin
				entries_q <= cfg_data;
			end
			if (query_go) begin
				scan_q  <= '0;
				count_q <= count_sel;
			end else if (rd_en) begin
				scan_q <= scan_q + CW'(1);
			end
			if (query_go || finish) begin
				pv_q <= 1'b0;
			end else if (v_s2 && hit_s2) begin
				pv_q <= 1'b1;
			end
		end
	end

	aabb_ram #(
		.WIDTH (aabb_pkg::ENTRY_W),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (wr_en),
		.waddr (AW'(entry_index)),
		.wdata ({pos_x, pos_y, radius_x, radius_y}),
		.re    (rd_en),
		.raddr (AW'(scan_q)),
		.rdata (rd_data)
	);

	assign epx_s1 = $signed(rd_data[61:46]);
	assign epy_s1 = $signed(rd_data[45:30]);
	assign erx_s1 = rd_data[29:15];
	assign ery_s1 = rd_data[14:0];

	// query operands, entry index and stage payload
	always_ff @(posedge clk) begin
		if (query_go) begin
			qpx_q <= pos_x;
			qpy_q <= pos_y;
			qrx_q <= radius_x;
			qry_q <= radius_y;
		end
		if (rd_en) begin
			idx_s1 <= scan_q[3:0];
		end
		if (v_s1) begin
			idx_s2 <= idx_s1;
			sx_s2  <= aabb_pkg::axis_sum(qpx_q, qrx_q, epx_s1, erx_s1);
			sy_s2  <= aabb_pkg::axis_sum(qpy_q, qry_q, epy_s1, ery_s1);
			gtx_s2 <= (qpx_q > epx_s1);
			gty_s2 <= (qpy_q > epy_s1);
			epx_s2 <= epx_s1;
			epy_s2 <= epy_s1;
			erx_s2 <= erx_s1;
			ery_s2 <= ery_s1;
		end
	end

	assign hit_s2 = (sx_s2 > 18'sd0) && (sy_s2 > 18'sd0);
	assign cx_s2  = aabb_pkg::axis_center(sx_s2, gtx_s2, epx_s2, erx_s2);
	assign cy_s2  = aabb_pkg::axis_center(sy_s2, gty_s2, epy_s2, ery_s2);

	// hold the newest hit, emit the previous one
	always_ff @(posedge clk) begin
		if (v_s2 && hit_s2) begin
			pidx_q <= idx_s2;
			pcx_q  <= cx_s2;
			pcy_q  <= cy_s2;
			phx_q  <= sx_s2[15:1];
			phy_q  <= sy_s2[15:1];
		end
		if (finish) begin
			hit_q  <= pv_q;
			last_q <= 1'b1;
			idx_q  <= pv_q ? pidx_q : 4'd0;
			cx_q   <= pv_q ? pcx_q : 16'sd0;
			cy_q   <= pv_q ? pcy_q : 16'sd0;
			hx_q   <= pv_q ? phx_q : 15'd0;
			hy_q   <= pv_q ? phy_q : 15'd0;
		end else if (v_s2 && hit_s2 && pv_q) begin
			hit_q  <= 1'b1;
			last_q <= 1'b0;
			idx_q  <= pidx_q;
			cx_q   <= pcx_q;
			cy_q   <= pcy_q;
			hx_q   <= phx_q;
			hy_q   <= phy_q;
		end
	end

	assign strobe           = strobe_q;
	assign hit              = hit_q;
	assign last             = last_q;
	assign match_index      = idx_q;
	assign overlap_center_x = cx_q;
	assign overlap_center_y = cy_q;
	assign overlap_half_x   = hx_q;
	assign overlap_half_y   = hy_q;

	`AABB_ASSERT_NEXT(a_finish_emits, state_q == aabb_pkg::ST_FINISH, strobe_q && last_q, "no final beat")
	`AABB_ASSERT_NOW(a_mid_beat_busy, strobe_q && !last_q, busy, "mid beat while idle")
	`AABB_ASSERT_NOW(a_miss_is_last, strobe_q && !hit_q, last_q, "miss beat not last")
	`AABB_ASSERT_NEXT(a_query_busy, query_go, busy, "query taken, not busy")
	`AABB_ASSERT_NOW(a_scan_bound, state_q == aabb_pkg::ST_SCAN, scan_q <= count_q, "scan past count")

endmodule
